[sv/page_transition_counter_defines.svh]
// assertion macros for the page transition counter
// used by modules that check their own logic; needs clk_i and rst_ni in scope
`ifndef PAGE_TRANSITION_COUNTER_DEFINES_SVH
`define PAGE_TRANSITION_COUNTER_DEFINES_SVH

// checked only outside reset
`define PTC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define PTC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[sv/ptc_pkg.sv]
// shared types, constants and helpers of the page transition counter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

  // default sizes of the tables
  localparam int FILE_SLOTS_DEF = 4;
  localparam int PAGES_DEF      = 256;
  localparam int SUCCESSORS_DEF = 4;

  // fixed field widths
  localparam int SLOT_W     = 2;
  localparam int OFFSET_W   = 16;
  localparam int PAGE_OUT_W = 8;
  localparam int COUNT_W    = 16;
  localparam int STATUS_W   = 2;
  localparam int LIMIT_W    = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_COUNTED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

  typedef struct packed {
    logic [SLOT_W-1:0]   file_slot;
    logic [OFFSET_W-1:0] page_offset;
  } in_word_t;

  typedef struct packed {
    logic [PAGE_OUT_W-1:0] from_page;
    logic [PAGE_OUT_W-1:0] to_page;
    logic [COUNT_W-1:0]    pair_count;
    logic [COUNT_W-1:0]    total_count;
    logic [STATUS_W-1:0]   status;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic capture;
    logic set_reject;
    logic set_first;
    logic lookup;
    logic commit;
    logic load_out;
  } ptc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic skip;
    logic reject;
    logic first;
    logic out_free;
  } ptc_stat_t;

  // saturating increment of a count
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 16'd1;
  endfunction

endpackage

`default_nettype wire

[sv/ptc_ctrl.sv]
// controller of the page transition counter: sequences clear, check, lookup,
// update and output of one word; depends on ptc_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire ptc_pkg::ptc_stat_t stat_i,
  output ptc_pkg::ptc_cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_EVAL,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // commands decoded from state and status
  always_comb begin
    cmd_o            = '0;
    cmd_o.clear      = (state_q == S_CLEAR);
    cmd_o.capture    = accept;
    cmd_o.set_reject = (state_q == S_CHECK) && !stat_i.skip && stat_i.reject;
    cmd_o.set_first  = (state_q == S_CHECK) && !stat_i.skip && !stat_i.reject &&
                       stat_i.first;
    cmd_o.lookup     = (state_q == S_CHECK) && !stat_i.skip && !stat_i.reject &&
                       !stat_i.first;
    cmd_o.commit     = (state_q == S_EVAL);
    cmd_o.load_out   = (state_q == S_EMIT) && stat_i.out_free;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (stat_i.clear_done) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_CHECK;
      S_CHECK: begin
        if (stat_i.skip || (!stat_i.reject && stat_i.first)) begin
          state_d = S_IDLE;
        end else if (stat_i.reject) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_EVAL;
        end
      end
      S_EVAL:  state_d = S_EMIT;
      S_EMIT:  if (stat_i.out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[sv/ptc_datapath.sv]
// datapath of the page transition counter: last-page store, successor row
// memory, row update logic and output register; depends on ptc_pkg and the defines
`timescale 1ns / 1ps
`default_nettype none

`include "page_transition_counter_defines.svh"

module ptc_datapath #(
  parameter int FILE_SLOTS = ptc_pkg::FILE_SLOTS_DEF,
  parameter int PAGES      = ptc_pkg::PAGES_DEF,
  parameter int SUCCESSORS = ptc_pkg::SUCCESSORS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  input  wire logic [ptc_pkg::LIMIT_W-1:0] cfg_data_i,
  input  wire ptc_pkg::in_word_t           in_data_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output ptc_pkg::out_word_t               out_data_o,
  input  wire ptc_pkg::ptc_cmd_t           cmd_i,
  output ptc_pkg::ptc_stat_t               stat_o
);

  localparam int SLOT_IW = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
  localparam int PW      = $clog2(PAGES);
  localparam int ROWS    = FILE_SLOTS * PAGES;
  localparam int RW      = $clog2(ROWS);
  localparam int SW      = (SUCCESSORS > 1) ? $clog2(SUCCESSORS) : 1;
  localparam int CW      = ptc_pkg::COUNT_W;
  localparam int OPW     = ptc_pkg::PAGE_OUT_W;
  localparam int OFW     = ptc_pkg::OFFSET_W;

  // configuration
  logic [ptc_pkg::LIMIT_W-1:0] limit_q;

  // captured word and per-file state
  ptc_pkg::in_word_t     in_q;
  logic [PW-1:0]         prev_q;
  logic [FILE_SLOTS-1:0] last_valid_q;
  logic [PW-1:0]         last_mem [FILE_SLOTS];

  // successor row memory
  logic [SUCCESSORS-1:0]          valid_mem [ROWS];
  logic [SUCCESSORS-1:0][PW-1:0]  page_mem  [ROWS];
  logic [SUCCESSORS-1:0][CW-1:0]  cnt_mem   [ROWS];
  logic [CW-1:0]                  total_mem [ROWS];

  logic [SUCCESSORS-1:0]          rd_valid_q;
  logic [SUCCESSORS-1:0][PW-1:0]  rd_page_q;
  logic [SUCCESSORS-1:0][CW-1:0]  rd_cnt_q;
  logic [CW-1:0]                  rd_total_q;
  logic [RW-1:0]                  row_q;
  logic [RW-1:0]                  clr_addr_q;

  ptc_pkg::out_word_t res_q, res_d;
  ptc_pkg::out_word_t out_q;
  logic               out_valid_q;

  logic [SLOT_IW-1:0] slot_ix;
  logic [PW-1:0]      page_ix;
  logic [RW-1:0]      row_addr;
  logic               slot_ok, page_ok;

  logic [SUCCESSORS-1:0]         hit_vec, free_vec;
  logic [SW-1:0]                 hit_ix, free_ix, sel_ix;
  logic                          hit_any, free_any, row_full;
  logic [CW-1:0]                 pair_new, total_new;
  logic [SUCCESSORS-1:0]         new_valid;
  logic [SUCCESSORS-1:0][PW-1:0] new_page;
  logic [SUCCESSORS-1:0][CW-1:0] new_cnt;

  // checks on the captured word
  assign slot_ix  = SLOT_IW'(in_q.file_slot);
  assign page_ix  = PW'(in_q.page_offset);
  assign slot_ok  = int'(in_q.file_slot) < FILE_SLOTS;
  assign page_ok  = ((OFW + 1)'(in_q.page_offset) < (OFW + 1)'(PAGES)) &&
                    (in_q.page_offset < OFW'(limit_q));
  assign row_addr = RW'(slot_ix) * RW'(PAGES) + RW'(prev_q);

  assign stat_o.clear_done = (clr_addr_q == RW'(ROWS - 1));
  assign stat_o.skip       = !slot_ok;
  assign stat_o.reject     = !page_ok;
  assign stat_o.first      = !last_valid_q[slot_ix];
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // row search: lowest matching entry, lowest free entry
  always_comb begin
    hit_vec = '0;
    free_vec = '0;
    hit_ix = '0;
    free_ix = '0;
    for (int k = 0; k < SUCCESSORS; k++) begin
      hit_vec[k]  = rd_valid_q[k] && (rd_page_q[k] == page_ix);
      free_vec[k] = !rd_valid_q[k];
    end
    for (int k = SUCCESSORS - 1; k >= 0; k--) begin
      if (hit_vec[k]) hit_ix = SW'(k);
      if (free_vec[k]) free_ix = SW'(k);
    end
  end

  assign hit_any   = |hit_vec;
  assign free_any  = |free_vec;
  assign row_full  = !hit_any && !free_any;
  assign sel_ix    = hit_any ? hit_ix : free_ix;
  assign pair_new  = hit_any ? ptc_pkg::sat_inc(rd_cnt_q[hit_ix]) : CW'(1);
  assign total_new = ptc_pkg::sat_inc(rd_total_q);

  // updated row
  always_comb begin
    new_valid         = rd_valid_q;
    new_page          = rd_page_q;
    new_cnt           = rd_cnt_q;
    new_valid[sel_ix] = 1'b1;
    new_page[sel_ix]  = page_ix;
    new_cnt[sel_ix]   = pair_new;
  end

  // result word
  always_comb begin
    res_d = res_q;
    if (cmd_i.set_reject) begin
      res_d        = '0;
      res_d.status = ptc_pkg::STATUS_RANGE;
    end else if (cmd_i.commit) begin
      res_d.from_page = OPW'(prev_q);
      res_d.to_page   = OPW'(in_q.page_offset);
      if (row_full) begin
        res_d.pair_count  = '0;
        res_d.total_count = rd_total_q;
        res_d.status      = ptc_pkg::STATUS_FULL;
      end else begin
        res_d.pair_count  = pair_new;
        res_d.total_count = total_new;
        res_d.status      = ptc_pkg::STATUS_COUNTED;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      <= ptc_pkg::LIMIT_RESET;
      last_valid_q <= '0;
      clr_addr_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) limit_q <= cfg_data_i;
      if (cmd_i.set_first) last_valid_q[slot_ix] <= 1'b1;
      if (cmd_i.clear) clr_addr_q <= clr_addr_q + RW'(1);
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) in_q <= in_data_i;
    if (cmd_i.lookup) row_q <= row_addr;
    res_q <= res_d;
    if (cmd_i.load_out) out_q <= res_q;
  end

  // last page store
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) prev_q <= last_mem[SLOT_IW'(in_data_i.file_slot)];
    if (cmd_i.set_first || cmd_i.commit) last_mem[slot_ix] <= page_ix;
  end

  // successor row memory: one read, one write a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      rd_valid_q <= valid_mem[row_addr];
      rd_page_q  <= page_mem[row_addr];
      rd_cnt_q   <= cnt_mem[row_addr];
      rd_total_q <= total_mem[row_addr];
    end
    if (cmd_i.clear) begin
      valid_mem[clr_addr_q] <= '0;
      total_mem[clr_addr_q] <= '0;
    end else if (cmd_i.commit && !row_full) begin
      valid_mem[row_q] <= new_valid;
      page_mem[row_q]  <= new_page;
      cnt_mem[row_q]   <= new_cnt;
      total_mem[row_q] <= total_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a row never holds the same successor twice
  `PTC_ASSERT(a_single_hit, cmd_i.commit |-> ($countones(hit_vec) <= 1), "duplicate successor")
  // a committed lookup never yields the range code
  `PTC_ASSERT(a_commit_status, cmd_i.commit |=> (res_q.status != ptc_pkg::STATUS_RANGE), "bad status")
  // a loaded word is offered on the next cycle
  `PTC_ASSERT(a_load_valid, cmd_i.load_out |=> out_valid_q, "word lost")
  // nothing is offered while the clearing pass runs
  `PTC_ASSERT_ALWAYS(a_clear_quiet, cmd_i.clear |-> !out_valid_q, "output during clear")

endmodule

`default_nettype wire

[sv/page_transition_counter.sv]
// A counted or full-row word passes the input, row read, result and output registers;
// an out-of-range word skips the row read. An in-range first access or unknown slot
// gives no word. No new input is taken while one is in flight: the next waits for the
// read, compare and write-back of its row; a waiting word also holds off the next input.
// Reset: asynchronous, active low; a clearing pass over all FILE_SLOTS*PAGES rows
// follows, during which no input is taken (configuration writes still are).
`timescale 1ns / 1ps
`default_nettype none

module page_transition_counter #(
  parameter int FILE_SLOTS = ptc_pkg::FILE_SLOTS_DEF,
  parameter int PAGES      = ptc_pkg::PAGES_DEF,
  parameter int SUCCESSORS = ptc_pkg::SUCCESSORS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ptc_pkg::LIMIT_W-1:0] cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire ptc_pkg::in_word_t           in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output ptc_pkg::out_word_t               out_data_o
);

  ptc_pkg::ptc_cmd_t  cmd;
  ptc_pkg::ptc_stat_t stat;

  // page limit register always takes a write
  assign cfg_ready_o = 1'b1;

  ptc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ptc_datapath #(
    .FILE_SLOTS (FILE_SLOTS),
    .PAGES      (PAGES),
    .SUCCESSORS (SUCCESSORS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire
